// ===== rtl/http_header_section_parser_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the HTTP header section parser
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HTTP_HEADER_SECTION_PARSER_ASSERT_SVH
`define HTTP_HEADER_SECTION_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// property that must hold at every edge out of reset
`define HHSP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define HHSP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HHSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define HHSP_ASSERT(label, clk, rst, prop, msg)
`define HHSP_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define HHSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/hhsp_pkg.sv =====
// ----------------------------------------------------------------------------
// hhsp_pkg
// Shared types, character constants and byte classification for the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hhsp_pkg;

   typedef enum logic [1:0] {
      PH_START   = 2'd0,
      PH_HEADERS = 2'd1,
      PH_DONE    = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_START_LINE = 2'd0,
      KIND_HEADER     = 2'd1,
      KIND_END        = 2'd2,
      KIND_ERROR      = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CAUSE_NONE      = 2'd0,
      CAUSE_NO_CR     = 2'd1,
      CAUSE_BINARY    = 2'd2,
      CAUSE_MALFORMED = 2'd3
   } cause_type;

   typedef enum logic [1:0] {
      FAULT_NONE      = 2'd0,
      FAULT_BINARY    = 2'd2,
      FAULT_MALFORMED = 2'd3
   } fault_type;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TILDE = 8'h7E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // status line layout: "HTTP/1.x NNN reason"
   localparam int PREFIX_LEN     = 7;
   localparam int MINOR_POS      = 7;
   localparam int SPACE1_POS     = 8;
   localparam int DIGIT_LAST_POS = 11;
   localparam int SPACE2_POS     = 12;
   localparam int START_LINE_MIN = 14;

   typedef struct packed {
      logic [7:0] value;
      logic       is_lf;
      logic       is_cr;
      logic       is_space;
      logic       is_ctl;     // below space
      logic       is_high;    // above tilde
      logic       is_bin;     // control other than CR, or above tilde
      logic       le_space;
      logic       is_digit;
      logic [3:0] digit;
   } byte_class_type;

   typedef struct packed {
      logic           sof;
      byte_class_type cls;
   } token_type;

   function automatic byte_class_type classify(logic [7:0] b);
      byte_class_type c;
      c.value    = b;
      c.is_lf    = (b == CHAR_LF);
      c.is_cr    = (b == CHAR_CR);
      c.is_space = (b == CHAR_SPACE);
      c.is_ctl   = (b < CHAR_SPACE);
      c.is_high  = (b > CHAR_TILDE);
      c.is_bin   = (c.is_ctl && !c.is_cr) || c.is_high;
      c.le_space = (b <= CHAR_SPACE);
      c.is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      c.digit    = b[3:0];
      return c;
   endfunction

   function automatic logic [7:0] prefix_char(logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0: ch = 8'h48;   // H
         3'd1: ch = 8'h54;   // T
         3'd2: ch = 8'h54;   // T
         3'd3: ch = 8'h50;   // P
         3'd4: ch = 8'h2F;   // /
         3'd5: ch = 8'h31;   // 1
         3'd6: ch = 8'h2E;   // .
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/hhsp_front.sv =====
// ----------------------------------------------------------------------------
// hhsp_front
// Request intake: decodes each byte into character classes and pushes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hhsp_front
   import hhsp_pkg::*;
(
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_start_of_message,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       queue_full,
   output logic            push,
   output token_type       push_token
);

   assign req_stall      = queue_full;
   assign push           = req_valid && !queue_full;
   assign push_token.sof = req_start_of_message;
   assign push_token.cls = classify(req_in_byte);

endmodule

`default_nettype wire

// ===== rtl/hhsp_queue.sv =====
// ----------------------------------------------------------------------------
// hhsp_queue
// Two-entry token queue between intake and the line parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "http_header_section_parser_assert.svh"

module hhsp_queue
   import hhsp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire token_type push_token,
   input  wire logic      pop,
   output logic           out_valid,
   output token_type      out_token,
   output logic           full
);

   token_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign out_valid = (count_ff != '0);
   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign out_token = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_token;
      end
   end

   `HHSP_ASSERT(a_q_bound, clock, reset, count_ff <= QCNT_W'(QUEUE_DEPTH), "queue count above depth")
   `HHSP_ASSERT_IMP(a_q_no_underflow, clock, reset, pop, count_ff != '0, "pop from empty queue")
   `HHSP_ASSERT_IMP(a_q_grow, clock, reset, !$past(reset) && $past(push) && !$past(pop), count_ff == $past(count_ff) + 1'b1, "queue count did not grow on push")

endmodule

`default_nettype wire

// ===== rtl/hhsp_back.sv =====
// ----------------------------------------------------------------------------
// hhsp_back
// Line parser: tracks line state per byte and registers one response per LF until the head ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "http_header_section_parser_assert.svh"

module hhsp_back
   import hhsp_pkg::*;
#(
   parameter int MAX_LINE = 8192
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        parse_mode,
   input  wire logic        tok_valid,
   input  wire token_type   tok,
   output logic             tok_pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_line_kind,
   output logic [1:0]       rsp_error_cause,
   output logic             rsp_http_minor,
   output logic [9:0]       rsp_status_code,
   output logic [13:0]      rsp_line_length
);

   localparam int POS_W = $clog2(MAX_LINE + 1);

   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic             cr_pending;
      logic             last_space;
      fault_type        fault;
      logic [1:0]       spaces;
      logic             minor;
      logic [9:0]       status;
   } line_state_type;

   localparam line_state_type LINE_CLEAR = '0;

   function automatic line_state_type take_content(line_state_type s, byte_class_type c,
                                                    logic in_start, logic resp);
      line_state_type   n;
      logic             bad;
      logic [POS_W-1:0] p;
      n   = s;
      bad = 1'b0;
      p   = s.pos;
      if (in_start) begin
         if (resp) begin
            if (p < POS_W'(PREFIX_LEN)) begin
               bad = (c.value != prefix_char(p[2:0]));
            end else if (p == POS_W'(MINOR_POS)) begin
               if (c.value == CHAR_ZERO) begin
                  n.minor = 1'b0;
               end else if (c.value == CHAR_ONE) begin
                  n.minor = 1'b1;
               end else begin
                  bad = 1'b1;
               end
            end else if (p == POS_W'(SPACE1_POS) || p == POS_W'(SPACE2_POS)) begin
               bad = !c.is_space;
            end else if (p <= POS_W'(DIGIT_LAST_POS)) begin
               if (c.is_digit) begin
                  // times ten, wrapping at ten bits
                  n.status = (s.status << 3) + (s.status << 1) + {6'd0, c.digit};
               end else begin
                  bad = 1'b1;
               end
            end else begin
               bad = c.is_ctl || c.is_high;
            end
         end else begin
            if (c.is_ctl) begin
               bad = 1'b1;
            end
            if (s.last_space && c.le_space) begin
               bad = 1'b1;
            end
            if (c.is_space && s.spaces != 2'd3) begin
               n.spaces = s.spaces + 2'd1;
            end
         end
      end
      if (c.is_bin) begin
         n.fault = FAULT_BINARY;
      end else if (bad && s.fault == FAULT_NONE) begin
         n.fault = FAULT_MALFORMED;
      end
      n.last_space = c.is_space;
      if (p < POS_W'(MAX_LINE)) begin
         n.pos = p + 1'b1;
      end
      return n;
   endfunction

   phase_type      phase_ff, phase_in;
   line_state_type line_ff, line_in;
   logic           rsp_valid_ff, rsp_valid_in;
   kind_type       kind_ff, kind_in;
   cause_type      cause_ff, cause_in;
   logic           minor_ff, minor_in;
   logic [9:0]     status_ff, status_in;
   logic [13:0]    length_ff, length_in;

   logic           out_free;
   logic           produce;
   phase_type      ph0;
   line_state_type s0, s1;
   logic           start_bad;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   // an LF waits in the queue until the response register can take it
   assign tok_pop  = tok_valid && (!tok.cls.is_lf || out_free);

   always_comb begin
      ph0       = tok.sof ? PH_START : phase_ff;
      s0        = tok.sof ? LINE_CLEAR : line_ff;
      s1        = s0;
      start_bad = 1'b0;
      phase_in  = phase_ff;
      line_in   = line_ff;
      produce   = 1'b0;
      kind_in   = KIND_ERROR;
      cause_in  = CAUSE_NONE;
      minor_in  = 1'b0;
      status_in = '0;
      length_in = 14'(s0.pos);

      if (tok_pop) begin
         phase_in = ph0;
         line_in  = s0;
         if (ph0 != PH_DONE) begin
            if (!tok.cls.is_lf) begin
               // a CR not followed by LF becomes ordinary line content
               if (s0.cr_pending) begin
                  s1.cr_pending = 1'b0;
                  s1 = take_content(s1, classify(CHAR_CR), ph0 == PH_START, parse_mode);
               end
               if (tok.cls.is_cr) begin
                  s1.cr_pending = 1'b1;
               end else begin
                  s1 = take_content(s1, tok.cls, ph0 == PH_START, parse_mode);
               end
               line_in = s1;
            end else begin
               produce = 1'b1;
               line_in = LINE_CLEAR;
               if (!s0.cr_pending) begin
                  kind_in  = KIND_ERROR;
                  cause_in = CAUSE_NO_CR;
               end else if (s0.fault == FAULT_BINARY) begin
                  kind_in  = KIND_ERROR;
                  cause_in = CAUSE_BINARY;
               end else if (ph0 == PH_START) begin
                  start_bad = (s0.fault != FAULT_NONE) || s0.last_space;
                  if (parse_mode) begin
                     start_bad = start_bad || (s0.pos < POS_W'(START_LINE_MIN))
                                 || (s0.status == '0);
                  end else begin
                     start_bad = start_bad || (s0.spaces != 2'd2);
                  end
                  if (start_bad) begin
                     kind_in  = KIND_ERROR;
                     cause_in = CAUSE_MALFORMED;
                  end else begin
                     kind_in = KIND_START_LINE;
                     if (parse_mode) begin
                        minor_in  = s0.minor;
                        status_in = s0.status;
                     end
                  end
               end else if (s0.pos == '0) begin
                  kind_in = KIND_END;
               end else begin
                  kind_in = KIND_HEADER;
               end
               case (kind_in)
                  KIND_ERROR, KIND_END: phase_in = PH_DONE;
                  KIND_START_LINE:      phase_in = PH_HEADERS;
                  default:              phase_in = ph0;
               endcase
            end
         end
      end

      rsp_valid_in = produce || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         line_ff      <= LINE_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         line_ff      <= line_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         kind_ff   <= kind_in;
         cause_ff  <= cause_in;
         minor_ff  <= minor_in;
         status_ff <= status_in;
         length_ff <= length_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_line_kind   = kind_ff;
   assign rsp_error_cause = cause_ff;
   assign rsp_http_minor  = minor_ff;
   assign rsp_status_code = status_ff;
   assign rsp_line_length = length_ff;

   `HHSP_ASSERT_NEXT(a_b_done, clock, reset, produce && (kind_in == KIND_ERROR || kind_in == KIND_END), phase_ff == PH_DONE, "parser not done after end or error")
   `HHSP_ASSERT_IMP(a_b_cause, clock, reset, rsp_valid_ff && kind_ff != KIND_ERROR, cause_ff == CAUSE_NONE, "cause set on a good line")
   `HHSP_ASSERT_IMP(a_b_status, clock, reset, rsp_valid_ff && kind_ff != KIND_START_LINE, status_ff == '0 && !minor_ff, "status on a non start line")

endmodule

`default_nettype wire

// ===== rtl/http_header_section_parser.sv =====
// ----------------------------------------------------------------------------
// http_header_section_parser
// HTTP/1.x message head checker: one byte per request, one response per line of the head.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  req_      in         req_valid/req_stall   start_of_message, in_byte
//  rsp_      out        rsp_valid/rsp_stall   line_kind, error_cause, http_minor,
//                                             status_code, line_length
//  csr_      in         csr_wr_en             wr_data = parse_mode
//
//  One byte per cycle unless stalled; an LF goes to the queue, then the response register.
//  The per-byte state update in the parser sets the rate.
//  Synchronous reset empties the queue, returns to the start line, mode response.
//  A stalled response holds its register; later LF bytes wait in the queue.
//  req_stall rises once two bytes are queued.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module http_header_section_parser
   import hhsp_pkg::*;
#(
   parameter int MAX_LINE = 8192
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_start_of_message,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_line_kind,
   output logic [1:0]       rsp_error_cause,
   output logic             rsp_http_minor,
   output logic [9:0]       rsp_status_code,
   output logic [13:0]      rsp_line_length,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data
);

   logic      parse_mode_ff, parse_mode_in;
   logic      push, pop, queue_full, tok_valid;
   token_type push_token, tok;

   assign parse_mode_in = csr_wr_en ? csr_wr_data : parse_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         parse_mode_ff <= 1'b1;
      end else begin
         parse_mode_ff <= parse_mode_in;
      end
   end

   hhsp_front u_front (
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_start_of_message (req_start_of_message),
      .req_in_byte          (req_in_byte),
      .queue_full           (queue_full),
      .push                 (push),
      .push_token           (push_token)
   );

   hhsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .pop        (pop),
      .out_valid  (tok_valid),
      .out_token  (tok),
      .full       (queue_full)
   );

   hhsp_back #(
      .MAX_LINE (MAX_LINE)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .parse_mode      (parse_mode_ff),
      .tok_valid       (tok_valid),
      .tok             (tok),
      .tok_pop         (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_line_kind   (rsp_line_kind),
      .rsp_error_cause (rsp_error_cause),
      .rsp_http_minor  (rsp_http_minor),
      .rsp_status_code (rsp_status_code),
      .rsp_line_length (rsp_line_length)
   );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for http_header_section_parser. Directed message heads
// cover status lines, request lines, line faults, mode changes and a long
// line; random heads, mostly well-formed with some corrupted, follow. Each
// accepted request byte runs through a local line parser, and the queued
// line reports are checked field by field against the response channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import hhsp_pkg::*;

   localparam int LINE_MAX     = 8192;
   localparam int ITEM_TARGET  = 1150;
   localparam int LONG_BYTES   = 150;
   localparam int DRAIN        = 8;

   localparam logic [7:0] LF     = 8'h0A;
   localparam logic [7:0] CR     = 8'h0D;
   localparam logic [7:0] SP     = 8'h20;
   localparam logic [7:0] TILDE  = 8'h7E;
   localparam logic [7:0] DIGIT0 = 8'h30;
   localparam logic [7:0] DIGIT1 = 8'h31;
   localparam logic [7:0] DIGIT9 = 8'h39;
   localparam logic [55:0] VERSION_TEXT = "HTTP/1.";

   typedef struct {
      kind_type    kind;
      cause_type   cause;
      logic        minor;
      logic [9:0]  status;
      logic [13:0] length;
   } line_report_type;

   typedef enum {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_TOGGLE} stall_style_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_start_of_message = 1'b0;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_line_kind;
   logic [1:0]  rsp_error_cause;
   logic        rsp_http_minor;
   logic [9:0]  rsp_status_code;
   logic [13:0] rsp_line_length;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;

   http_header_section_parser #(.MAX_LINE(LINE_MAX)) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_start_of_message (req_start_of_message),
      .req_in_byte          (req_in_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_line_kind        (rsp_line_kind),
      .rsp_error_cause      (rsp_error_cause),
      .rsp_http_minor       (rsp_http_minor),
      .rsp_status_code      (rsp_status_code),
      .rsp_line_length      (rsp_line_length),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // line parser state
   // ------------------------------------------------------------------
   logic       resp_mode = 1'b1;
   phase_type  msg_phase = PH_START;
   int         line_pos = 0;
   logic       cr_held = 1'b0;
   logic       prev_space = 1'b0;
   fault_type  line_err = FAULT_NONE;
   logic [1:0] spaces = 2'd0;
   logic       minor_seen = 1'b0;
   logic [9:0] status_seen = 10'd0;

   line_report_type pending_lines[$];
   logic [8:0]      msg_bytes[$];
   int              errors = 0;
   int              taken_count = 0;
   int              burst_left = 0;
   int              stall_left = 0;
   stall_style_type stall_style = STALL_NONE;

   function automatic void clear_line();
      line_pos    = 0;
      cr_held     = 1'b0;
      prev_space  = 1'b0;
      line_err    = FAULT_NONE;
      spaces      = 2'd0;
      minor_seen  = 1'b0;
      status_seen = 10'd0;
   endfunction

   function automatic void absorb_byte(logic [7:0] b);
      int   p;
      logic bin;
      logic bad;
      p   = line_pos;
      bin = (b < SP && b != CR) || b > TILDE;
      bad = 1'b0;
      if (msg_phase == PH_START) begin
         if (resp_mode) begin
            if (p < 7) begin
               bad = (b != VERSION_TEXT[8 * (6 - p) +: 8]);
            end else if (p == 7) begin
               if (b == DIGIT0) minor_seen = 1'b0;
               else if (b == DIGIT1) minor_seen = 1'b1;
               else bad = 1'b1;
            end else if (p == 8 || p == 12) begin
               bad = (b != SP);
            end else if (p <= 11) begin
               if (b >= DIGIT0 && b <= DIGIT9)
                  status_seen = 10'(int'(status_seen) * 10 + int'(b) - int'(DIGIT0));
               else
                  bad = 1'b1;
            end else begin
               bad = (b < SP || b > TILDE);
            end
         end else begin
            if (b < SP) bad = 1'b1;
            if (prev_space && b <= SP) bad = 1'b1;
            if (b == SP && spaces < 2'd3) spaces = spaces + 2'd1;
         end
      end
      if (bin) line_err = FAULT_BINARY;
      else if (bad && line_err == FAULT_NONE) line_err = FAULT_MALFORMED;
      prev_space = (b == SP);
      if (p < LINE_MAX) line_pos = p + 1;
   endfunction

   // returns 1 when the byte completes a line
   function automatic bit parse_byte(input logic sof, input logic [7:0] b,
                                     output line_report_type r);
      logic bad;
      r = '{KIND_START_LINE, CAUSE_NONE, 1'b0, 10'd0, 14'd0};
      if (sof) begin
         msg_phase = PH_START;
         clear_line();
      end
      if (msg_phase == PH_DONE) return 1'b0;
      if (b != LF) begin
         if (cr_held) begin
            cr_held = 1'b0;
            absorb_byte(CR);
         end
         if (b == CR) cr_held = 1'b1;
         else absorb_byte(b);
         return 1'b0;
      end
      if (!cr_held) begin
         r.kind  = KIND_ERROR;
         r.cause = CAUSE_NO_CR;
      end else if (line_err == FAULT_BINARY) begin
         r.kind  = KIND_ERROR;
         r.cause = CAUSE_BINARY;
      end else if (msg_phase == PH_START) begin
         bad = (line_err != FAULT_NONE) || prev_space;
         if (resp_mode) bad = bad || line_pos < 14 || status_seen == 10'd0;
         else bad = bad || spaces != 2'd2;
         if (bad) begin
            r.kind  = KIND_ERROR;
            r.cause = CAUSE_MALFORMED;
         end else if (resp_mode) begin
            r.minor  = minor_seen;
            r.status = status_seen;
         end
      end else if (line_pos == 0) begin
         r.kind = KIND_END;
      end else begin
         r.kind = KIND_HEADER;
      end
      r.length = 14'(line_pos);
      if (r.kind == KIND_ERROR || r.kind == KIND_END) msg_phase = PH_DONE;
      else if (r.kind == KIND_START_LINE) msg_phase = PH_HEADERS;
      clear_line();
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------
   task automatic send_byte(logic sof, logic [7:0] b);
      line_report_type r;
      @(negedge clock);
      req_valid            = 1'b1;
      req_start_of_message = sof;
      req_in_byte          = b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      taken_count++;
      if (parse_byte(sof, b, r)) pending_lines.push_back(r);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                  : $urandom_range(0, 12);
      end
   endtask

   task automatic send_line(logic sof, string body, bit crlf = 1'b1);
      for (int i = 0; i < body.len(); i++) send_byte(sof && i == 0, body[i]);
      if (crlf) begin
         send_byte(sof && body.len() == 0, CR);
         send_byte(1'b0, LF);
      end
   endtask

   // parser must be idle before the mode register changes
   task automatic quiesce();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_lines.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_mode(logic value);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      resp_mode   = value;
   endtask

   // ------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_style = stall_style_type'($urandom_range(0, 3));
         stall_left  = $urandom_range(4, 80);
      end else begin
         stall_left--;
      end
      case (stall_style)
         STALL_NONE:  rsp_stall = 1'b0;
         STALL_HALF:  rsp_stall = $urandom_range(0, 1);
         STALL_HEAVY: rsp_stall = ($urandom_range(0, 3) != 0);
         default:     rsp_stall = stall_left[0];
      endcase
   end

   task automatic report_mismatch(string what, int got, int want);
      $display("ERROR at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      line_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_lines.size() == 0) begin
            report_mismatch("unexpected response, line_kind", rsp_line_kind, -1);
         end else begin
            want = pending_lines.pop_front();
            if (rsp_line_kind !== want.kind)
               report_mismatch("line_kind", rsp_line_kind, want.kind);
            if (rsp_error_cause !== want.cause)
               report_mismatch("error_cause", rsp_error_cause, want.cause);
            if (rsp_http_minor !== want.minor)
               report_mismatch("http_minor", rsp_http_minor, want.minor);
            if (rsp_status_code !== want.status)
               report_mismatch("status_code", rsp_status_code, want.status);
            if (rsp_line_length !== want.length)
               report_mismatch("line_length", rsp_line_length, want.length);
         end
      end
   end

   // ------------------------------------------------------------------
   // random message heads
   // ------------------------------------------------------------------
   function automatic void push_char(logic [7:0] b);
      msg_bytes.push_back({1'b0, b});
   endfunction

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i]);
   endfunction

   function automatic void push_crlf();
      push_char(CR);
      push_char(LF);
   endfunction

   // printable run; spaces only when allowed
   function automatic void push_token(int lo, int hi, bit with_space);
      repeat ($urandom_range(lo, hi))
         push_char(8'($urandom_range(with_space ? 32'h20 : 32'h21, 32'h7E)));
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 5))
         0:       return CR;
         1:       return LF;
         2:       return SP;
         3:       return 8'($urandom_range(32'h21, 32'h7E));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void build_message();
      int code;
      int idx;
      msg_bytes.delete();
      if ($urandom_range(0, 19) == 0) begin
         repeat ($urandom_range(4, 40)) push_char(noise_byte());
      end else begin
         if (resp_mode) begin
            push_text("HTTP/1.");
            if ($urandom_range(0, 15) == 0) push_char(8'($urandom_range(32'h30, 32'h39)));
            else push_char(8'(DIGIT0 + $urandom_range(0, 1)));
            push_char(SP);
            code = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 999);
            push_char(8'(DIGIT0 + code / 100));
            push_char(8'(DIGIT0 + (code / 10) % 10));
            push_char(8'(DIGIT0 + code % 10));
            push_char(SP);
            push_token(1, 1, 1'b0);
            push_token(0, 8, 1'b1);
         end else begin
            push_token(1, 6, 1'b0);
            push_char(SP);
            push_token(1, 8, 1'b0);
            push_char(SP);
            push_token(1, 8, 1'b0);
         end
         push_crlf();
         repeat ($urandom_range(0, 5)) begin
            push_token(1, 8, 1'b0);
            push_text(": ");
            push_token(0, 10, 1'b1);
            push_crlf();
         end
         push_crlf();
         if ($urandom_range(0, 3) == 0) begin
            idx = $urandom_range(0, msg_bytes.size() - 1);
            case ($urandom_range(0, 2))
               0:       msg_bytes[idx] = {1'b0, noise_byte()};
               1:       msg_bytes.insert(idx, {1'b0, noise_byte()});
               default: msg_bytes.delete(idx);
            endcase
         end
      end
      // trailing bytes after the end are ignored until the next sof
      repeat ($urandom_range(0, 3)) push_char(noise_byte());
      msg_bytes[0][8] = ($urandom_range(0, 9) != 0);
   endfunction

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic test_status_lines();
      send_line(1'b1, "HTTP/1.1 200 OK");
      send_line(1'b0, "Host: x");
      send_line(1'b0, "");
      send_line(1'b0, "ignored");
      send_line(1'b1, "HTTP/1.0 999 ~");
      send_line(1'b0, "");
      send_line(1'b1, "HTTP/1.1 000 Zero");
      send_line(1'b1, "HTTP/1.1 200 ");
      send_line(1'b1, "");
      send_line(1'b1, "HTTP/2.0 200 OK");
   endtask

   task automatic test_line_faults();
      send_byte(1'b1, LF);
      send_line(1'b1, "HTTP/1.1 201 A");
      send_line(1'b0, "a", 1'b0);
      send_byte(1'b0, LF);
      send_line(1'b1, "HTTP/1.1 404 N");
      send_byte(1'b0, 8'h00);
      send_byte(1'b0, 8'hFF);
      send_line(1'b0, "z");
      // missing CR wins over binary
      send_line(1'b1, "HTTP/1.1 500 E");
      send_byte(1'b0, 8'h7F);
      send_byte(1'b0, LF);
      // interior CR is content in a header line
      send_line(1'b1, "HTTP/1.0 302 F");
      send_line(1'b0, "a\015b");
      send_line(1'b0, "a\015");
      send_line(1'b0, "");
      send_line(1'b1, "HTTP/1.1 200 O\015K");
      send_line(1'b1, "HTTP/1.1 200 \001");
   endtask

   task automatic test_request_lines();
      quiesce();
      write_mode(1'b0);
      send_line(1'b1, "GET / HTTP/1.1");
      send_line(1'b0, "Host: a");
      send_line(1'b0, "");
      send_line(1'b1, "GET /  HTTP/1.1");
      send_line(1'b1, "GET / HTTP/1.1 ");
      send_line(1'b1, "GET /");
      send_line(1'b1, "GET\011/ HTTP/1.1");
      send_line(1'b1, "A B C D");
      send_line(1'b1, "A B\015C");
   endtask

   task automatic test_mode_switch();
      send_line(1'b1, "HTTP/1.1 2", 1'b0);
      quiesce();
      write_mode(1'b1);
      send_line(1'b0, "00 OK");
      send_line(1'b1, "HTTP/1.1 301 M", 1'b0);
      quiesce();
      write_mode(1'b0);
      send_line(1'b0, "oved");
      send_line(1'b1, "GET /x", 1'b0);
      quiesce();
      write_mode(1'b1);
      send_line(1'b0, " HTTP/1.0");
   endtask

   task automatic test_long_line();
      quiesce();
      write_mode(1'b0);
      send_line(1'b1, "GET / HTTP/1.1");
      repeat (LONG_BYTES) send_byte(1'b0, "a");
      send_line(1'b0, "");
      send_line(1'b0, "");
   endtask

   task automatic test_random_messages();
      while (taken_count < ITEM_TARGET) begin
         if ($urandom_range(0, 4) == 0) begin
            quiesce();
            write_mode($urandom_range(0, 1));
         end
         build_message();
         foreach (msg_bytes[i]) send_byte(msg_bytes[i][8], msg_bytes[i][7:0]);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_status_lines();
      test_line_faults();
      test_request_lines();
      test_mode_switch();
      test_long_line();
      test_random_messages();
      quiesce();
      if (errors == 0 && pending_lines.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d responses outstanding", pending_lines.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
